// ----- rtl/stc_pkg.sv -----
package stc_pkg;

    localparam int MAX_TOKEN = 32;
    localparam int ADDR_W    = $clog2(MAX_TOKEN);
    localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
    localparam int NUM_WORDS = 18;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int WORD_CHARS = 8;

    localparam logic [WIDX_W-1:0] WIDX_INT    = WIDX_W'(0);
    localparam logic [WIDX_W-1:0] WIDX_HEADER = WIDX_W'(16);
    localparam logic [WIDX_W-1:0] WIDX_TYPO   = WIDX_W'(17);

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_PLAIN   = 3'd3;
    localparam logic [2:0] KIND_OPER    = 3'd4;
    localparam logic [2:0] KIND_PUNCT   = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef logic [8*WORD_CHARS-1:0] t_word;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [2:0]       kind;
        logic             trunc;
        logic             use_fixed;
        logic             has_op;
        logic [2:0]       op_kind;
        logic [7:0]       op_char;
    } t_job;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] text_char;
        logic       token_end;
        logic       run_end;
        logic       truncated;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    // word text left aligned, zero padded
    function automatic t_word word_text(input logic [WIDX_W-1:0] w);
        t_word t;
        case (w)
            5'd0:    t = {"int", 40'd0};
            5'd1:    t = {"char", 32'd0};
            5'd2:    t = {"float", 24'd0};
            5'd3:    t = {"double", 16'd0};
            5'd4:    t = {"if", 48'd0};
            5'd5:    t = {"else", 32'd0};
            5'd6:    t = {"for", 40'd0};
            5'd7:    t = {"while", 24'd0};
            5'd8:    t = {"do", 48'd0};
            5'd9:    t = {"switch", 16'd0};
            5'd10:   t = {"case", 32'd0};
            5'd11:   t = {"break", 24'd0};
            5'd12:   t = {"continue"};
            5'd13:   t = {"return", 16'd0};
            5'd14:   t = {"void", 32'd0};
            5'd15:   t = {"class", 24'd0};
            5'd16:   t = {"#include"};
            5'd17:   t = {"itn", 40'd0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] word_len(input logic [WIDX_W-1:0] w);
        logic [3:0] n;
        case (w)
            5'd0, 5'd6, 5'd17:          n = 4'd3;
            5'd1, 5'd5, 5'd10, 5'd14:   n = 4'd4;
            5'd2, 5'd7, 5'd11, 5'd15:   n = 4'd5;
            5'd3, 5'd9, 5'd13:          n = 4'd6;
            5'd4, 5'd8:                 n = 4'd2;
            5'd12, 5'd16:               n = 4'd8;
            default:                    n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] word_char(input logic [WIDX_W-1:0] w,
                                             input logic [2:0] pos);
        t_word t;
        t = word_text(w);
        return t[8*WORD_CHARS-1 - 8*pos -: 8];
    endfunction

endpackage

// ----- rtl/stc_if.sv -----
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;

    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] text_char;
    logic       token_end;
    logic       run_end;
    logic       truncated;

    modport source (output valid, output kind, output text_char, output token_end,
                    output run_end, output truncated, input ready);
    modport sink   (input valid, input kind, input text_char, input token_end,
                    input run_end, input truncated, output ready);
endinterface

// ----- rtl/stc_ram.sv -----
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/stc_fifo.sv -----
module stc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stc_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output stc_pkg::t_job o_data,
    output logic          o_empty
);
    stc_pkg::t_job r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = r_count[1];
    assign o_empty = (r_count == 2'd0);
endmodule

// ----- rtl/stc_front.sv -----
module stc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stc_in_if.sink           i_in,
    input  logic             i_store_done,
    input  logic             i_q_full,
    output logic             o_push,
    output stc_pkg::t_job    o_job,
    output stc_pkg::t_ram_wr o_ram_wr
);
    logic [stc_pkg::LEN_W-1:0]     r_len, n_len;
    logic                          r_quote, n_quote;
    logic                          r_ovf, n_ovf;
    logic                          r_busy, n_busy;
    logic [stc_pkg::NUM_WORDS-1:0] r_match, n_match;

    logic       fire;
    logic [7:0] c;
    logic       is_delim, is_oper, is_punct;
    logic       do_flush, classed, has_op, append;
    logic [2:0] op_kind;
    logic [stc_pkg::NUM_WORDS-1:0] full_hit, step_match;
    logic       kw_hit;
    logic [2:0] flush_kind;
    logic       use_fixed;

    assign c    = i_in.char_code;
    assign fire = i_in.valid && i_in.ready;
    assign i_in.ready = !i_q_full && !r_busy;

    assign is_delim = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    assign is_oper  = (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
                      (c == "%") || (c == "=");
    assign is_punct = (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
                      (c == ";") || (c == "[") || (c == "]");

    always_comb begin
        for (int w = 0; w < stc_pkg::NUM_WORDS; w++) begin
            full_hit[w] = r_match[w] &&
                (r_len == stc_pkg::LEN_W'(stc_pkg::word_len(stc_pkg::WIDX_W'(w))));
            step_match[w] = r_match[w] && (r_len < stc_pkg::LEN_W'(stc_pkg::WORD_CHARS)) &&
                (c == stc_pkg::word_char(stc_pkg::WIDX_W'(w), r_len[2:0]));
        end
    end

    assign kw_hit = |full_hit[15:0];

    always_comb begin
        do_flush = 1'b0;
        classed  = 1'b0;
        has_op   = 1'b0;
        append   = 1'b0;
        op_kind  = stc_pkg::KIND_OPER;
        if (i_in.command) begin
            do_flush = 1'b1;
            classed  = 1'b1;
        end else if (!r_quote && is_delim) begin
            do_flush = 1'b1;
            classed  = 1'b1;
        end else if (!r_quote && is_oper) begin
            do_flush = 1'b1;
            has_op   = 1'b1;
        end else if (!r_quote && is_punct) begin
            do_flush = 1'b1;
            has_op   = 1'b1;
            op_kind  = stc_pkg::KIND_PUNCT;
        end else begin
            append = 1'b1;
        end
    end

    always_comb begin
        flush_kind = stc_pkg::KIND_PLAIN;
        use_fixed  = 1'b0;
        if (classed) begin
            flush_kind = stc_pkg::KIND_IDENT;
            if (!r_ovf) begin
                if (kw_hit) begin
                    flush_kind = stc_pkg::KIND_KEYWORD;
                end else if (full_hit[stc_pkg::WIDX_HEADER]) begin
                    flush_kind = stc_pkg::KIND_HEADER;
                end else if (full_hit[stc_pkg::WIDX_TYPO]) begin
                    flush_kind = stc_pkg::KIND_KEYWORD;
                    use_fixed  = 1'b1;
                end
            end
        end
    end

    assign o_job.len       = r_len;
    assign o_job.kind      = flush_kind;
    assign o_job.trunc     = r_ovf;
    assign o_job.use_fixed = use_fixed;
    assign o_job.has_op    = has_op;
    assign o_job.op_kind   = op_kind;
    assign o_job.op_char   = c;
    assign o_push = fire && do_flush && (has_op || (r_len != '0));

    assign o_ram_wr.en   = fire && append && (r_len < stc_pkg::LEN_W'(stc_pkg::MAX_TOKEN));
    assign o_ram_wr.addr = r_len[stc_pkg::ADDR_W-1:0];
    assign o_ram_wr.data = c;

    always_comb begin
        n_len   = r_len;
        n_quote = r_quote;
        n_ovf   = r_ovf;
        n_match = r_match;
        n_busy  = r_busy;
        if (i_store_done) begin
            n_busy = 1'b0;
        end
        if (fire) begin
            if (i_in.command) begin
                n_quote = 1'b0;
            end
            if (do_flush) begin
                if (r_len != '0) begin
                    n_busy = 1'b1;
                end
                n_len   = '0;
                n_ovf   = 1'b0;
                n_match = '1;
            end else if (append) begin
                if (c == stc_pkg::CH_QUOTE) begin
                    n_quote = !r_quote;
                end
                if (o_ram_wr.en) begin
                    n_len   = r_len + stc_pkg::LEN_W'(1);
                    n_match = step_match;
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_quote <= 1'b0;
            r_ovf   <= 1'b0;
            r_busy  <= 1'b0;
            r_match <= '1;
        end else begin
            r_len   <= n_len;
            r_quote <= n_quote;
            r_ovf   <= n_ovf;
            r_busy  <= n_busy;
            r_match <= n_match;
        end
    end
endmodule

// ----- rtl/stc_back.sv -----
module stc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  stc_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_rd_en,
    output logic [stc_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_store_done,
    stc_out_if.source                  o_out
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;
    localparam logic [1:0] S_OP    = 2'd3;

    logic [1:0]                 r_state, n_state;
    stc_pkg::t_job              r_job, n_job;
    logic [stc_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic                       r_out_valid, n_out_valid;
    stc_pkg::t_result           r_out, n_out;

    logic       out_free;
    logic       last;
    logic [7:0] ch;

    assign out_free = !r_out_valid || o_out.ready;
    assign last = ({1'b0, r_idx} == (r_job.len - stc_pkg::LEN_W'(1)));
    assign ch = r_job.use_fixed ? stc_pkg::word_char(stc_pkg::WIDX_INT, r_idx[2:0])
                                : i_rd_data;

    assign o_rd_en   = (r_state == S_FETCH);
    assign o_rd_addr = r_idx;

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_idx        = r_idx;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        o_pop        = 1'b0;
        o_store_done = 1'b0;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_idx = '0;
                    n_state = (i_job.len != '0) ? S_FETCH : S_OP;
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = r_job.kind;
                    n_out.text_char = ch;
                    n_out.token_end = last;
                    n_out.run_end   = last && !r_job.has_op;
                    n_out.truncated = r_job.trunc;
                    if (last) begin
                        o_store_done = 1'b1;
                        n_state = r_job.has_op ? S_OP : S_IDLE;
                    end else begin
                        n_idx   = r_idx + stc_pkg::ADDR_W'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            S_OP: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = r_job.op_kind;
                    n_out.text_char = r_job.op_char;
                    n_out.token_end = 1'b1;
                    n_out.run_end   = 1'b1;
                    n_out.truncated = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out.kind;
    assign o_out.text_char = r_out.text_char;
    assign o_out.token_end = r_out.token_end;
    assign o_out.run_end   = r_out.run_end;
    assign o_out.truncated = r_out.truncated;
endmodule

// ----- rtl/source_char_tokenizer.sv -----
// source character tokenizer
// i_in: one beat per source character (command = 0) or end of line (command = 1)
// o_out: one beat per emitted character; kind, token_end, run_end and truncated
//   travel with each character, run_end marks the last beat caused by an input
// a character that only extends the current token gives no output beat
// the front classifies each beat, keeps the token in a 32-entry RAM and tracks
//   string mode and keyword prefix matches; flush jobs go into a two-entry queue
// the back takes a job from the queue, then drains it one token character at a
//   time (RAM read, then output register load), then the operator or punctuation
//   character if any; with the back idle, a flushing input beat passes through the
//   queue, the RAM read and the output register to the output, and an operator or
//   punctuation beat with no token skips the RAM read
// input ready drops while the queue is full or while the back still reads the token
//   RAM for a previous flush; ordinary characters are otherwise taken every cycle
// a stalled output holds its beat in the output register; the back and then the
//   front stall behind it
// reset clears string mode, token length, overflow flag, queue and output valid;
//   no RAM clearing is needed
module source_char_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stc_in_if.sink     i_in,
    stc_out_if.source  o_out
);
    logic             q_push, q_pop, q_full, q_empty;
    stc_pkg::t_job    q_in, q_out;
    stc_pkg::t_ram_wr ram_wr;
    logic             rd_en;
    logic [stc_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             store_done;

    stc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_store_done (store_done),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (q_in),
        .o_ram_wr     (ram_wr)
    );

    stc_ram #(
        .WIDTH (8),
        .DEPTH (stc_pkg::MAX_TOKEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    stc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    stc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (q_out),
        .o_pop        (q_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_store_done (store_done),
        .o_out        (o_out)
    );
endmodule

// ----- rtl/stc_checker.sv -----
module stc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_kind,
    input logic [7:0] i_text_char,
    input logic       i_token_end,
    input logic       i_run_end,
    input logic       i_truncated
);
    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) &&
        $stable(i_text_char) && $stable(i_token_end) && $stable(i_run_end) &&
        $stable(i_truncated))
        else $error("output beat changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_kind <= stc_pkg::KIND_PUNCT)
        else $error("kind out of range");

    a_single_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == stc_pkg::KIND_OPER || i_kind == stc_pkg::KIND_PUNCT)
        |-> i_token_end && i_run_end && !i_truncated)
        else $error("operator or punctuation beat malformed");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_run_end |-> i_token_end)
        else $error("run end inside a token");

    a_class_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == stc_pkg::KIND_KEYWORD || i_kind == stc_pkg::KIND_HEADER)
        |-> !i_truncated)
        else $error("truncated token classed as keyword or header");
endmodule

bind source_char_tokenizer stc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_text_char (o_out.text_char),
    .i_token_end (o_out.token_end),
    .i_run_end   (o_out.run_end),
    .i_truncated (o_out.truncated)
);
